// File: sv/lpbs_pkg.sv
// ----------------------------------------------------------------------------
// lpbs_pkg
// Shared types and constants for the polar bin scan table: stream field
// layout, kind codes, register map and controller/datapath interface.
// ----------------------------------------------------------------------------
package lpbs_pkg;

  // field widths
  localparam int KIND_W     = 3;
  localparam int ANG_W      = 16;
  localparam int DIST_W     = 18;
  localparam int QUAL_W     = 8;
  localparam int RA_W       = 9;
  localparam int FIRST_W    = 9;
  localparam int LAST_W     = 10;
  localparam int YAW_W      = 16;

  // s_tdata layout, lowest bit up
  localparam int ANG_LSB    = 0;
  localparam int DIST_LSB   = 16;
  localparam int QUAL_LSB   = 34;
  localparam int RA_LSB     = 42;
  localparam int FIRST_LSB  = 51;
  localparam int LAST_LSB   = 60;
  localparam int THR_LSB    = 70;
  localparam int YAW_LSB    = 88;
  localparam int IN_DATA_W  = 104;

  localparam int OUT_PAD_W  = 4;
  localparam int OUT_DATA_W = 32;

  // angle scaling: bin = (angle_q14 * 90) >> 14
  localparam int NODE_SCALE = 90;
  localparam int SCALE_W    = 7;
  localparam int ANGLE_FRAC = 14;

  // constant-modulo unit: operand width and reciprocal precision
  localparam int MOD_W      = 16;
  localparam int MOD_K      = 25;

  // yaw is biased by half range so the modulo unit sees an unsigned value
  localparam int             YAW_HALF = 32768;
  localparam logic [YAW_W-1:0] YAW_FLIP = 16'h8000;

  // input kinds
  localparam logic [KIND_W-1:0] KIND_CLEAR  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_NODE   = 3'd1;
  localparam logic [KIND_W-1:0] KIND_READ   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_QUERY  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_ROTATE = 3'd4;

  // modulo unit operand source
  localparam logic [1:0] SRC_NODE  = 2'd0;
  localparam logic [1:0] SRC_FIRST = 2'd1;
  localparam logic [1:0] SRC_YAW   = 2'd2;

  // register map
  localparam int ADDR_W = 3;
  localparam int REG_W  = 32;
  localparam logic REG_MIN_RANGE = 1'b0;
  localparam logic REG_MAX_RANGE = 1'b1;
  localparam logic [DIST_W-1:0] MAX_RANGE_RESET = 18'd16000;

  typedef struct packed {
    logic       capture;
    logic       mod_load;
    logic [1:0] mod_src;
    logic       mod_mul;
    logic       mod_qb;
    logic       mod_rem;
    logic       clr_step;
    logic       off_clear;
    logic       node_write;
    logic       rot_apply;
    logic       read_set;
    logic       res_read;
    logic       q_set;
    logic       q_next;
    logic       res_found;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic span_empty;
    logic hit;
    logic at_last;
  } sts_t;

endpackage

// File: sv/lpbs_regs.sv
// ----------------------------------------------------------------------------
// lpbs_regs
// APB register file holding the lower and upper range limits.
// ----------------------------------------------------------------------------
module lpbs_regs import lpbs_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [REG_W-1:0]  pwdata,
  output logic [REG_W-1:0]  prdata,
  output logic              pready,
  output logic [DIST_W-1:0] min_range,
  output logic [DIST_W-1:0] max_range
);

  logic reg_idx;
  logic wr;

  assign reg_idx = paddr[ADDR_W-1];
  assign pready  = 1'b1;
  assign wr      = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_range <= '0;
      max_range <= MAX_RANGE_RESET;
    end else if (wr) begin
      unique case (reg_idx)
        REG_MIN_RANGE: min_range <= pwdata[DIST_W-1:0];
        REG_MAX_RANGE: max_range <= pwdata[DIST_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_MIN_RANGE: prdata = REG_W'(min_range);
      REG_MAX_RANGE: prdata = REG_W'(max_range);
    endcase
  end

endmodule

// File: sv/lpbs_ctrl.sv
// ----------------------------------------------------------------------------
// lpbs_ctrl
// Sequencer: steps the datapath through each item kind, the bin sweeps and
// the result hand-off to the output register.
// ----------------------------------------------------------------------------
module lpbs_ctrl import lpbs_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [KIND_W-1:0] kind,
  output logic              m_tvalid,
  input  logic              m_tready,
  input  sts_t              sts,
  output cmd_t              cmd
);

  localparam logic [3:0] S_INIT  = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_CLR   = 4'd2;
  localparam logic [3:0] S_MOD0  = 4'd3;
  localparam logic [3:0] S_MOD1  = 4'd4;
  localparam logic [3:0] S_MOD2  = 4'd5;
  localparam logic [3:0] S_MOD3  = 4'd6;
  localparam logic [3:0] S_NODE  = 4'd7;
  localparam logic [3:0] S_ROT   = 4'd8;
  localparam logic [3:0] S_RSET  = 4'd9;
  localparam logic [3:0] S_RWAIT = 4'd10;
  localparam logic [3:0] S_RCAP  = 4'd11;
  localparam logic [3:0] S_QSET  = 4'd12;
  localparam logic [3:0] S_QWAIT = 4'd13;
  localparam logic [3:0] S_QCMP  = 4'd14;
  localparam logic [3:0] S_DONE  = 4'd15;

  logic [3:0]        state;
  logic [3:0]        state_next;
  logic [KIND_W-1:0] kind_r;

  assign s_tready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_INIT: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.capture = 1'b1;
          unique case (kind)
            KIND_CLEAR:  state_next = S_CLR;
            KIND_NODE:   state_next = S_MOD0;
            KIND_QUERY:  state_next = S_MOD0;
            KIND_ROTATE: state_next = S_MOD0;
            KIND_READ:   state_next = S_RSET;
            default:     state_next = S_DONE;
          endcase
        end
      end
      S_CLR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) begin
          cmd.off_clear = 1'b1;
          state_next    = S_DONE;
        end
      end
      S_MOD0: begin
        cmd.mod_load = 1'b1;
        unique case (kind_r)
          KIND_NODE:  cmd.mod_src = SRC_NODE;
          KIND_QUERY: cmd.mod_src = SRC_FIRST;
          default:    cmd.mod_src = SRC_YAW;
        endcase
        state_next = S_MOD1;
      end
      S_MOD1: begin
        cmd.mod_mul = 1'b1;
        state_next  = S_MOD2;
      end
      S_MOD2: begin
        cmd.mod_qb = 1'b1;
        state_next = S_MOD3;
      end
      S_MOD3: begin
        cmd.mod_rem = 1'b1;
        unique case (kind_r)
          KIND_NODE:  state_next = S_NODE;
          KIND_QUERY: state_next = S_QSET;
          default:    state_next = S_ROT;
        endcase
      end
      S_NODE: begin
        cmd.node_write = 1'b1;
        state_next     = S_DONE;
      end
      S_ROT: begin
        cmd.rot_apply = 1'b1;
        state_next    = S_DONE;
      end
      S_RSET: begin
        cmd.read_set = 1'b1;
        state_next   = S_RWAIT;
      end
      S_RWAIT: begin
        state_next = S_RCAP;
      end
      S_RCAP: begin
        cmd.res_read = 1'b1;
        state_next   = S_DONE;
      end
      S_QSET: begin
        cmd.q_set  = 1'b1;
        state_next = sts.span_empty ? S_DONE : S_QWAIT;
      end
      S_QWAIT: begin
        state_next = S_QCMP;
      end
      S_QCMP: begin
        priority if (sts.hit) begin
          cmd.res_found = 1'b1;
          state_next    = S_DONE;
        end else if (sts.at_last) begin
          state_next = S_DONE;
        end else begin
          cmd.q_next = 1'b1;
          state_next = S_QWAIT;
        end
      end
      S_DONE: begin
        if (!m_tvalid || m_tready) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_INIT;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) kind_r <= kind;
  end

endmodule

// File: sv/lpbs_datapath.sv
// ----------------------------------------------------------------------------
// lpbs_datapath
// Bin memory, rotation offset, constant-modulo unit, query walker and
// result / output registers.
// ----------------------------------------------------------------------------
module lpbs_datapath import lpbs_pkg::*; #(
  parameter int BINS          = 360,
  parameter int QUALITY_SHIFT = 2
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [IN_DATA_W-1:0]  s_tdata,
  input  cmd_t                  cmd,
  output sts_t                  sts,
  input  logic [DIST_W-1:0]     min_range,
  input  logic [DIST_W-1:0]     max_range,
  output logic [OUT_DATA_W-1:0] m_tdata
);

  localparam int IW       = $clog2(BINS);
  localparam int BW       = $clog2(BINS + 1);
  localparam int RECIP    = (1 << MOD_K) / BINS + 1;
  localparam int RW       = $clog2(RECIP + 1);
  localparam int PW       = MOD_W + RW;
  localparam int QW       = PW - MOD_K;
  localparam int YAW_BIAS = YAW_HALF % BINS;
  localparam int SW       = ANG_W + SCALE_W;

  // captured item
  logic [ANG_W-1:0]   ang;
  logic [DIST_W-1:0]  node_dist;
  logic [QUAL_W-1:0]  qual;
  logic [RA_W-1:0]    ra;
  logic [FIRST_W-1:0] first;
  logic [LAST_W-1:0]  last;
  logic [DIST_W-1:0]  thr;
  logic [YAW_W-1:0]   yaw;

  // state
  logic [DIST_W-1:0] dist_mem [BINS];
  logic [DIST_W-1:0] rdata;
  logic [IW-1:0]     off;
  logic [IW-1:0]     clr_idx;
  logic [IW-1:0]     pidx;
  logic [LAST_W-1:0] a;

  // modulo unit
  logic [MOD_W-1:0]   mod_in;
  logic [PW-1:0]      prod;
  logic [QW+BW-1:0]   qb;
  logic [IW-1:0]      mod_r;
  logic [MOD_W-1:0]   diff;
  logic [MOD_W-1:0]   mod_sel;
  logic [SW-1:0]      ang_scaled;

  // results
  logic [RA_W-1:0]   res_angle;
  logic [DIST_W-1:0] res_dist;
  logic              res_found;
  logic [RA_W-1:0]   out_angle;
  logic [DIST_W-1:0] out_dist;
  logic              out_found;

  logic              node_ok;
  logic              ra_ok;
  logic              we;
  logic [IW-1:0]     waddr;
  logic [DIST_W-1:0] wdata;
  logic [IW-1:0]     pnode;

  function automatic logic [IW-1:0] sub_mod(input logic [IW-1:0] x, input logic [IW-1:0] y);
    logic [IW:0] d;
    if (x >= y) d = {1'b0, x} - {1'b0, y};
    else        d = {1'b0, x} + (IW+1)'(BINS) - {1'b0, y};
    return d[IW-1:0];
  endfunction

  function automatic logic [IW-1:0] add_mod(input logic [IW-1:0] x, input logic [IW-1:0] y);
    logic [IW:0] s;
    s = {1'b0, x} + {1'b0, y};
    if (s >= (IW+1)'(BINS)) s = s - (IW+1)'(BINS);
    return s[IW-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      ang       <= s_tdata[ANG_LSB   +: ANG_W];
      node_dist <= s_tdata[DIST_LSB  +: DIST_W];
      qual      <= s_tdata[QUAL_LSB  +: QUAL_W];
      ra        <= s_tdata[RA_LSB    +: RA_W];
      first     <= s_tdata[FIRST_LSB +: FIRST_W];
      last      <= s_tdata[LAST_LSB  +: LAST_W];
      thr       <= s_tdata[THR_LSB   +: DIST_W];
      yaw       <= s_tdata[YAW_LSB   +: YAW_W];
    end
  end

  // modulo by BINS: reciprocal multiply, quotient back-multiply, one fix-up
  assign ang_scaled = SW'(ang) * SW'(NODE_SCALE);

  always_comb begin
    unique case (cmd.mod_src)
      SRC_NODE:  mod_sel = MOD_W'(ang_scaled[SW-1:ANGLE_FRAC]);
      SRC_FIRST: mod_sel = MOD_W'(first);
      default:   mod_sel = yaw ^ YAW_FLIP;
    endcase
  end

  assign diff = mod_in - MOD_W'(qb);

  always_ff @(posedge clk) begin
    if (cmd.mod_load) mod_in <= mod_sel;
    if (cmd.mod_mul)  prod   <= PW'(mod_in) * PW'(RECIP);
    if (cmd.mod_qb)   qb     <= (QW+BW)'(prod[PW-1:MOD_K]) * (QW+BW)'(BINS);
    if (cmd.mod_rem) begin
      mod_r <= (diff >= MOD_W'(BINS)) ? IW'(diff - MOD_W'(BINS)) : IW'(diff);
    end
  end

  assign node_ok = ((qual >> QUALITY_SHIFT) != '0) && (node_dist > min_range) &&
                   (node_dist < max_range);
  assign ra_ok   = (RA_W+1)'(ra) < (RA_W+1)'(BINS);
  assign pnode   = sub_mod(mod_r, off);

  assign we    = cmd.clr_step | (cmd.node_write & node_ok);
  assign waddr = cmd.clr_step ? clr_idx : pnode;
  assign wdata = cmd.clr_step ? '0 : node_dist;

  always_ff @(posedge clk) begin
    if (we) dist_mem[waddr] <= wdata;
    rdata <= dist_mem[pidx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      off     <= '0;
      clr_idx <= '0;
    end else begin
      if (cmd.clr_step) clr_idx <= sts.clr_last ? '0 : clr_idx + 1'b1;
      if (cmd.off_clear) begin
        off <= '0;
      end else if (cmd.rot_apply) begin
        off <= add_mod(off, sub_mod(mod_r, IW'(YAW_BIAS)));
      end
    end
  end

  // physical read pointer and logical span counter
  always_ff @(posedge clk) begin
    if (cmd.read_set) begin
      pidx <= ra_ok ? sub_mod(ra[IW-1:0], off) : '0;
    end else if (cmd.q_set) begin
      pidx <= sub_mod(mod_r, off);
    end else if (cmd.q_next) begin
      pidx <= (pidx == IW'(BINS - 1)) ? '0 : pidx + 1'b1;
    end
    if (cmd.q_set) begin
      a <= LAST_W'(first);
    end else if (cmd.q_next) begin
      a <= a + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      res_angle <= '0;
      res_dist  <= '0;
      res_found <= 1'b0;
    end else begin
      if (cmd.res_read) begin
        res_angle <= ra;
        res_dist  <= ra_ok ? rdata : '0;
      end
      if (cmd.res_found) res_found <= 1'b1;
    end
    if (cmd.out_load) begin
      out_angle <= res_angle;
      out_dist  <= res_dist;
      out_found <= res_found;
    end
  end

  assign sts.clr_last   = (clr_idx == IW'(BINS - 1));
  assign sts.span_empty = LAST_W'(first) > last;
  assign sts.hit        = (rdata > min_range) && (rdata < thr);
  assign sts.at_last    = (a == last);

  assign m_tdata = {{OUT_PAD_W{1'b0}}, out_found, out_dist, out_angle};

endmodule

// File: sv/lidar_polar_bin_scan.sv
// ----------------------------------------------------------------------------
// lidar_polar_bin_scan
// Polar scan binning table: one distance per whole-degree bin with a
// rotation offset, fed by clear / node / read / query / rotate items.
// ----------------------------------------------------------------------------
//
//  channel  dir  handshake              payload
//  -------  ---  ---------------------  ----------------------------------
//  s_*      in   s_tvalid / s_tready    s_tuser kind, s_tdata item fields
//  m_*      out  m_tvalid / m_tready    m_tdata one result per item
//  apb      in   psel, penable, pready  range limits at 0x0 and 0x4
//
//  One item in flight at a time: the next item is taken only after the
//  previous one has moved its result into the output register.
//  The query walk is bound by the single registered read port of the bin
//  memory (address, then data, then compare); nodes, query start and yaw go
//  through the four-step constant-modulo unit.
//  After reset a clearing pass zeroes the whole bin memory; s_tready
//  stays low meanwhile, register writes are taken as usual.
//  The result sits in an output register, so the next item is taken while
//  a finished transfer is still stalled on m_tready.
//
module lidar_polar_bin_scan import lpbs_pkg::*; #(
  parameter int BINS          = 360,
  parameter int QUALITY_SHIFT = 2
) (
  input  logic                  clk,
  input  logic                  rst,
  // stream in
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // [15:0] node_angle_q14, [33:16] node_distance_q2, [41:34] node_quality,
  // [50:42] read_angle, [59:51] range_first, [69:60] range_last,
  // [87:70] range_threshold_q2, [103:88] yaw_degrees
  input  logic [IN_DATA_W-1:0]  s_tdata,
  // [2:0] kind
  input  logic [KIND_W-1:0]     s_tuser,
  // stream out
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // [8:0] bin_angle, [26:9] bin_distance_q2, [27] object_found, [31:28] zero
  output logic [OUT_DATA_W-1:0] m_tdata,
  // configuration
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [ADDR_W-1:0]     paddr,
  input  logic [REG_W-1:0]      pwdata,
  output logic [REG_W-1:0]      prdata,
  output logic                  pready
);

  cmd_t              cmd;
  sts_t              sts;
  logic [DIST_W-1:0] min_range;
  logic [DIST_W-1:0] max_range;

  // range limits; the user must write them only while the block is idle, the block itself does not enforce it
  lpbs_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .min_range (min_range),
    .max_range (max_range)
  );

  // sequencer: owns the handshakes and the output valid flag
  lpbs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .kind     (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // bin memory, offset, modulo unit and result registers
  lpbs_datapath #(
    .BINS          (BINS),
    .QUALITY_SHIFT (QUALITY_SHIFT)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .s_tdata   (s_tdata),
    .cmd       (cmd),
    .sts       (sts),
    .min_range (min_range),
    .max_range (max_range),
    .m_tdata   (m_tdata)
  );

endmodule

// File: sv/lpbs_checker.sv
// ----------------------------------------------------------------------------
// lpbs_checker
// Port-level checks for the polar bin scan table, bound to the top level.
// ----------------------------------------------------------------------------
module lpbs_checker #(
  parameter int BINS = 360
) (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata
);

  // a stalled result transfer holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // no item taken while the reset clearing pass starts
  a_init_busy: assert property (@(posedge clk)
    rst |=> !s_tready)
    else $error("input ready straight after reset");

  a_out_pad: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[31:28] == 4'b0)
    else $error("output padding not zero");

  // a query result carries no bin echo or distance
  a_found_only: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[27] |-> m_tdata[26:0] == 27'b0)
    else $error("found flag mixed with read fields");

  // a non-zero distance only comes from a bin inside the table
  a_read_bin: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[26:9] != 18'b0) |-> (m_tdata[8:0] < BINS))
    else $error("distance reported for out-of-range bin");

endmodule

bind lidar_polar_bin_scan lpbs_checker #(.BINS(BINS)) u_lpbs_checker (.*);

// File: sim/lpbs_scan_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpbs_scan_checker
// Watches the item, result and register channels of the polar bin scan
// table. Keeps its own copy of the bin table, rotation offset and range
// limits, predicts one result per accepted item and compares every result
// transfer with the oldest prediction.
// ----------------------------------------------------------------------------
module lpbs_scan_checker import lpbs_pkg::*; #(
  parameter int BINS          = 360,
  parameter int QUALITY_SHIFT = 2
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  input  logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,
  input  logic [KIND_W-1:0]     s_tuser,
  input  logic                  m_tvalid,
  input  logic                  m_tready,
  input  logic [OUT_DATA_W-1:0] m_tdata,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [ADDR_W-1:0]     paddr,
  input  logic [REG_W-1:0]      pwdata,
  input  logic                  pready,
  output int unsigned           mismatches,
  output int unsigned           outstanding
);

  localparam logic [ADDR_W-1:0] MIN_ADDR = {REG_MIN_RANGE, 2'b00};
  localparam logic [ADDR_W-1:0] MAX_ADDR = {REG_MAX_RANGE, 2'b00};

  typedef struct packed {
    logic [RA_W-1:0]   bin_angle;
    logic [DIST_W-1:0] distance;
    logic              found;
  } bin_reply_t;

  logic [DIST_W-1:0] range_bins [BINS];
  int unsigned       rot_offset;
  logic [DIST_W-1:0] min_range;
  logic [DIST_W-1:0] max_range;
  bin_reply_t        due_replies [$];

  // logical bin -> stored entry under the current rotation
  function automatic int unsigned slot_of(int unsigned logical);
    return (logical % BINS + BINS - rot_offset % BINS) % BINS;
  endfunction

  function automatic bin_reply_t apply_item(logic [KIND_W-1:0] kind,
                                            logic [IN_DATA_W-1:0] f);
    bin_reply_t  reply;
    int unsigned bin, first, last, a, d;
    int          yaw;
    reply = '0;
    case (kind)
      KIND_CLEAR: begin
        foreach (range_bins[i]) range_bins[i] = '0;
        rot_offset = 0;
      end
      KIND_NODE: begin
        bin = ((32'(f[ANG_LSB +: ANG_W]) * NODE_SCALE) >> ANGLE_FRAC) % BINS;
        d   = f[DIST_LSB +: DIST_W];
        if ((f[QUAL_LSB +: QUAL_W] >> QUALITY_SHIFT) != 0 && d > min_range && d < max_range)
          range_bins[slot_of(bin)] = DIST_W'(d);
      end
      KIND_READ: begin
        reply.bin_angle = f[RA_LSB +: RA_W];
        if (reply.bin_angle < BINS) reply.distance = range_bins[slot_of(reply.bin_angle)];
      end
      KIND_QUERY: begin
        first = f[FIRST_LSB +: FIRST_W];
        last  = f[LAST_LSB +: LAST_W];
        for (a = first; a <= last && !reply.found; a++) begin
          d = range_bins[slot_of(a)];
          if (d > min_range && d < f[THR_LSB +: DIST_W]) reply.found = 1'b1;
        end
      end
      KIND_ROTATE: begin
        // mathematical modulo of the signed yaw
        yaw = int'($signed(f[YAW_LSB +: YAW_W])) % BINS;
        if (yaw < 0) yaw += BINS;
        rot_offset = (rot_offset + yaw) % BINS;
      end
      default: ;
    endcase
    return reply;
  endfunction

  task automatic flag(string field, int unsigned want, int unsigned got);
    $error("%s: expected %0d, actual %0d", field, want, got);
    mismatches++;
  endtask

  always @(posedge clk) begin
    bin_reply_t want, got;
    if (rst) begin
      foreach (range_bins[i]) range_bins[i] = '0;
      rot_offset  = 0;
      min_range   = '0;
      max_range   = MAX_RANGE_RESET;
      mismatches  = 0;
      outstanding = 0;
      due_replies.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr == MIN_ADDR) min_range = pwdata[DIST_W-1:0];
        else if (paddr == MAX_ADDR) max_range = pwdata[DIST_W-1:0];
      end
      // results first: a result in the same cycle belongs to an earlier item
      if (m_tvalid && m_tready) begin
        got.bin_angle = m_tdata[RA_W-1:0];
        got.distance  = m_tdata[RA_W +: DIST_W];
        got.found     = m_tdata[RA_W+DIST_W];
        if (due_replies.size() == 0) begin
          $error("result transfer %h with nothing expected", m_tdata);
          mismatches++;
        end else begin
          want = due_replies.pop_front();
          if (got.bin_angle != want.bin_angle) flag("bin_angle", want.bin_angle, got.bin_angle);
          if (got.distance != want.distance)
            flag("bin_distance_q2", want.distance, got.distance);
          if (got.found != want.found) flag("object_found", want.found, got.found);
          if (m_tdata[OUT_DATA_W-1 -: OUT_PAD_W] != '0)
            flag("padding", 0, m_tdata[OUT_DATA_W-1 -: OUT_PAD_W]);
        end
      end
      if (s_tvalid && s_tready) due_replies.push_back(apply_item(s_tuser, s_tdata));
      outstanding = due_replies.size();
    end
  end

endmodule

// File: sim/lidar_polar_bin_scan_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lidar_polar_bin_scan_test
// Drives the polar bin scan table with a directed run of edge cases and
// then six phases of random items under different range limits and
// handshake pressure; the checker beside the block does all comparing.
// ----------------------------------------------------------------------------
module lidar_polar_bin_scan_test;
  import lpbs_pkg::*;

  localparam int BINS            = 360;
  localparam int QUALITY_SHIFT   = 2;
  localparam int PHASES          = 6;
  localparam int ITEMS_PER_PHASE = 175;
  // worst single item is a query over 720 bins plus stalls
  localparam int STALL_LIMIT     = 10000;
  localparam int DRAIN_CYCLES    = 40;

  localparam logic [ADDR_W-1:0] MIN_ADDR = {REG_MIN_RANGE, 2'b00};
  localparam logic [ADDR_W-1:0] MAX_ADDR = {REG_MAX_RANGE, 2'b00};

  // kinds the block must ignore
  localparam int KIND_SPARE_FIRST = 5;
  localparam int KIND_SPARE_LAST  = 7;

  localparam logic [DIST_W-1:0] DIST_TOP = {DIST_W{1'b1}};

  // range limits per phase: full span, nominal, inverted extremes, wide, reset, narrow
  localparam int unsigned CFG_MIN [PHASES] = '{0, 500, 262143, 2000, 0, 100};
  localparam int unsigned CFG_MAX [PHASES] = '{262143, 16000, 0, 100000, 16000, 3000};

  typedef struct {
    logic [KIND_W-1:0]  kind;
    logic [ANG_W-1:0]   angle;
    logic [DIST_W-1:0]  distance;
    logic [QUAL_W-1:0]  quality;
    logic [RA_W-1:0]    read_bin;
    logic [FIRST_W-1:0] first;
    logic [LAST_W-1:0]  last;
    logic [DIST_W-1:0]  threshold;
    logic [YAW_W-1:0]   yaw;
  } scan_item_t;

  logic                  clk      = 1'b0;
  logic                  rst      = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata  = '0;
  logic [KIND_W-1:0]     s_tuser  = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  psel     = 1'b0;
  logic                  penable  = 1'b0;
  logic                  pwrite   = 1'b0;
  logic [ADDR_W-1:0]     paddr    = '0;
  logic [REG_W-1:0]      pwdata   = '0;
  logic [REG_W-1:0]      prdata;
  logic                  pready;

  int unsigned mismatches, outstanding;
  int unsigned quiet_cycles = 0;
  int          send_idle_pct = 36;
  int          take_idle_pct = 49;
  int unsigned cur_min = 0;
  int unsigned cur_max = MAX_RANGE_RESET;

  lidar_polar_bin_scan #(.BINS(BINS), .QUALITY_SHIFT(QUALITY_SHIFT)) dut (
    .clk, .rst,
    .s_tvalid, .s_tready, .s_tdata, .s_tuser,
    .m_tvalid, .m_tready, .m_tdata,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  lpbs_scan_checker #(.BINS(BINS), .QUALITY_SHIFT(QUALITY_SHIFT)) scoreboard (
    .clk, .rst,
    .s_tvalid, .s_tready, .s_tdata, .s_tuser,
    .m_tvalid, .m_tready, .m_tdata,
    .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .mismatches, .outstanding
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // result side: ready dropped at random per cycle, changed on the falling edge
  always @(negedge clk) m_tready <= ($urandom_range(0, 99) >= take_idle_pct);

  // watchdog: too long without any transfer or register write ends the run
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
        (psel && penable && pwrite && pready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [IN_DATA_W-1:0] pack_item(scan_item_t it);
    logic [IN_DATA_W-1:0] v;
    v = '0;
    v[ANG_LSB +: ANG_W]     = it.angle;
    v[DIST_LSB +: DIST_W]   = it.distance;
    v[QUAL_LSB +: QUAL_W]   = it.quality;
    v[RA_LSB +: RA_W]       = it.read_bin;
    v[FIRST_LSB +: FIRST_W] = it.first;
    v[LAST_LSB +: LAST_W]   = it.last;
    v[THR_LSB +: DIST_W]    = it.threshold;
    v[YAW_LSB +: YAW_W]     = it.yaw;
    return v;
  endfunction

  // smallest q14 angle that lands in whole-degree bin b
  function automatic logic [ANG_W-1:0] angle_of(int b);
    return ANG_W'((b * (1 << ANGLE_FRAC) + NODE_SCALE - 1) / NODE_SCALE);
  endfunction

  // every field random; fields the kind does not use stay as noise
  function automatic scan_item_t noise_item(logic [KIND_W-1:0] kind);
    scan_item_t it;
    it.kind      = kind;
    it.angle     = ANG_W'($urandom());
    it.distance  = DIST_W'($urandom());
    it.quality   = QUAL_W'($urandom());
    it.read_bin  = RA_W'($urandom());
    it.first     = FIRST_W'($urandom_range(0, BINS - 1));
    it.last      = LAST_W'($urandom_range(0, 2 * BINS - 1));
    it.threshold = DIST_W'($urandom());
    it.yaw       = YAW_W'($urandom());
    return it;
  endfunction

  // mostly inside the current limits, with the limits themselves and their
  // neighbours hit often
  function automatic logic [DIST_W-1:0] pick_distance();
    case ($urandom_range(0, 9))
      0: return DIST_W'($urandom());
      1: return DIST_W'(cur_min);
      2: return DIST_W'(cur_max);
      3: return DIST_W'(cur_min + 1);
      4: return DIST_W'(cur_max - 1);
      default: begin
        if (cur_max > cur_min + 1) return DIST_W'($urandom_range(cur_min + 1, cur_max - 1));
        return DIST_W'($urandom());
      end
    endcase
  endfunction

  function automatic scan_item_t random_item();
    scan_item_t it;
    int         r;
    r = $urandom_range(0, 99);
    if (r < 2)       it = noise_item(KIND_CLEAR);
    else if (r < 52) it = noise_item(KIND_NODE);
    else if (r < 70) it = noise_item(KIND_READ);
    else if (r < 85) it = noise_item(KIND_QUERY);
    else if (r < 93) it = noise_item(KIND_ROTATE);
    else it = noise_item(KIND_W'($urandom_range(KIND_SPARE_FIRST, KIND_SPARE_LAST)));
    case (it.kind)
      KIND_NODE: begin
        it.distance = pick_distance();
        // now and then a quality that shifts down to zero
        if ($urandom_range(0, 9) == 0) it.quality = QUAL_W'($urandom_range(0, 3));
      end
      KIND_READ: begin
        if ($urandom_range(0, 4) != 0) it.read_bin = RA_W'($urandom_range(0, BINS - 1));
      end
      KIND_QUERY: begin
        r = $urandom_range(0, 19);
        if (r < 14) it.last = LAST_W'(it.first + $urandom_range(0, 30));
        else if (r < 16) it.last = LAST_W'($urandom_range(0, 2 * BINS - 1));
        else if (r < 18 && it.first != 0) it.last = LAST_W'($urandom_range(0, it.first - 1));
        else it.last = LAST_W'(it.first + BINS - 1);  // whole circle, wrapping
        if ($urandom_range(0, 1) != 0) it.threshold = DIST_W'($urandom_range(cur_min, cur_max));
      end
      default: ;
    endcase
    return it;
  endfunction

  // present one item and hold it until the transfer; each cycle before it
  // the sender may idle, otherwise tvalid stays high into the next item
  task automatic send_item(scan_item_t it);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= it.kind;
    s_tdata  <= pack_item(it);
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  task automatic send_node(logic [ANG_W-1:0] angle, logic [DIST_W-1:0] distance,
                           logic [QUAL_W-1:0] quality);
    scan_item_t it;
    it          = noise_item(KIND_NODE);
    it.angle    = angle;
    it.distance = distance;
    it.quality  = quality;
    send_item(it);
  endtask

  task automatic send_read(int bin);
    scan_item_t it;
    it          = noise_item(KIND_READ);
    it.read_bin = RA_W'(bin);
    send_item(it);
  endtask

  task automatic send_query(int first, int last, logic [DIST_W-1:0] threshold);
    scan_item_t it;
    it           = noise_item(KIND_QUERY);
    it.first     = FIRST_W'(first);
    it.last      = LAST_W'(last);
    it.threshold = threshold;
    send_item(it);
  endtask

  task automatic send_rotate(logic [YAW_W-1:0] yaw);
    scan_item_t it;
    it     = noise_item(KIND_ROTATE);
    it.yaw = yaw;
    send_item(it);
  endtask

  // block is idle once every predicted result has been taken
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  // a setup phase and an access phase, then the bus is left idle
  task automatic write_reg(logic [ADDR_W-1:0] addr, logic [DIST_W-1:0] value);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= addr;
    pwdata  <= {(REG_W - DIST_W)'($urandom()), value};  // upper bits are don't-care
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  initial begin
    // reset released on a falling edge
    repeat (11) @(negedge clk);
    rst <= 1'b0;

    // ---- directed part, reset limits (0 / 16000) ----
    send_read(0);                              // table empty after the clearing pass
    send_node(angle_of(0), 1, 8'd4);           // just above min, lowest passing quality
    send_node(16'hFFFF, 15999, 8'hFF);         // largest angle -> bin 359, just below max
    send_read(359);
    send_node(angle_of(10), 16000, 8'hFF);     // on the upper limit: rejected
    send_node(angle_of(11), 0, 8'hFF);         // on the lower limit: rejected
    send_node(angle_of(12), 500, 8'd3);        // quality shifts to zero: rejected
    send_node(angle_of(13), DIST_TOP, 8'hFF);  // saturated distance: rejected
    send_read(12);
    send_node(angle_of(20), 100, 8'd200);      // two nodes in one bin, last one wins
    send_node(ANG_W'(angle_of(20) + 1), 200, 8'd200);
    send_read(20);
    send_read(BINS);                           // out of range: echo, distance 0
    send_query(0, 0, 2);                       // bin 0 holds 1, below threshold
    send_query(0, 0, 1);                       // threshold is exclusive
    send_query(5, 4, DIST_TOP);                // empty span
    send_query(350, 2 * BINS - 1, DIST_TOP);   // span wrapping past bin 0
    send_rotate(16'd1);
    send_read(1);                              // bin 0 content moved to bin 1
    send_rotate(16'hFFFF);                     // negative yaw
    send_rotate(16'h8000);                     // most negative yaw
    send_rotate(16'h7FFF);                     // most positive yaw
    for (int k = KIND_SPARE_FIRST; k <= KIND_SPARE_LAST; k++)
      send_item(noise_item(KIND_W'(k)));       // ignored kinds
    send_item(noise_item(KIND_CLEAR));
    send_read(359);

    // ---- random phases: new limits each phase, pressure shifting ----
    for (int p = 0; p < PHASES; p++) begin
      wait_drained();
      write_reg(MIN_ADDR, DIST_W'(CFG_MIN[p]));
      write_reg(MAX_ADDR, DIST_W'(CFG_MAX[p]));
      cur_min = CFG_MIN[p];
      cur_max = CFG_MAX[p];
      if (p < 2) begin
        send_idle_pct = 36;
        take_idle_pct = 49;
      end else if (p < 4) begin
        send_idle_pct = 49;
        take_idle_pct = 36;
      end else begin
        send_idle_pct = 0;
        take_idle_pct = 0;
      end
      repeat (ITEMS_PER_PHASE) send_item(random_item());
    end

    // let the last results through, then watch for stray transfers
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && outstanding == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
